[sv/irpwc_pkg.sv]
package irpwc_pkg;

   localparam int STORE_DEPTH  = 256;
   localparam int IDX_WIDTH    = $clog2(STORE_DEPTH);
   localparam int COUNT_WIDTH  = 16;
   localparam int PERIOD_WIDTH = 16;
   localparam int DUR_WIDTH    = 17;
   localparam int PULSE_WIDTH  = 8;
   localparam int TOTAL_WIDTH  = COUNT_WIDTH + 2;

   localparam logic [DUR_WIDTH-1:0]    DUR_MAX        = '1;
   localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET   = 16'd40000;
   localparam logic [DUR_WIDTH-1:0]    GAP_RESET      = 17'd40000;
   localparam logic [PULSE_WIDTH-1:0]  MAXPULSE_RESET = 8'd254;

   typedef enum logic [1:0] {
      OP_ARM  = 2'd0,
      OP_EDGE = 2'd1,
      OP_TICK = 2'd2,
      OP_READ = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      REG_PERIOD    = 2'd0,
      REG_GAP       = 2'd1,
      REG_MAXPULSES = 2'd2,
      REG_UNUSED    = 2'd3
   } reg_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_RECV = 2'd1,
      ST_END  = 2'd2
   } rx_state_type;

   // One write into the duration store.
   typedef struct packed {
      logic                 en;
      logic [IDX_WIDTH-1:0] addr;
      logic [DUR_WIDTH-1:0] data;
   } store_wr_type;

   // One read of the duration store.
   typedef struct packed {
      logic                 en;
      logic [IDX_WIDTH-1:0] addr;
   } store_rd_type;

endpackage

[sv/irpwc_store.sv]
module irpwc_store (
   input  logic                                clock,
   input  irpwc_pkg::store_wr_type             wr,
   input  irpwc_pkg::store_rd_type             rd,
   output logic [irpwc_pkg::DUR_WIDTH-1:0]     rdata_ff
);

   logic [irpwc_pkg::DUR_WIDTH-1:0] mem [irpwc_pkg::STORE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Read data holds while no read is issued, so a stalled result keeps it.
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rdata_ff <= mem[rd.addr];
      end
   end

endmodule

[sv/ir_pulse_width_capture.sv]
// Pulse timing capture for learning infrared remote codes.
//
// Command beats enter on the req_ channel: req_tuser carries the operation
// (arm, line edge, one-microsecond tick, read) and req_tdata the entry index
// used by a read. Every accepted beat produces exactly one result beat on the
// rsp_ channel in the next cycle. rsp_tdata carries the reception state, the
// number of stored durations and, for a read, the stored duration; rsp_tlast
// marks the beat that ended a reception.
// A new beat can be accepted every cycle unless a stalled result holds it
// off; the duration store is a one-port write, one-port read memory with a
// registered read, and every beat needs at most one write. The one exception,
// an end on the pulse limit that stores a duration and a terminator together,
// parks the terminator in a register and writes it in the following cycle,
// which is always free of other writes; reads of that entry then return zero.
// When rsp_tready is low the result register holds and req_tready drops, so
// no beat is lost; req_tready follows rsp_tready when the register is full.
// The csr_ port writes counter_period, gap_limit and max_pulses and is always
// ready. Synchronous reset restores the register defaults and the idle state;
// the store itself is not cleared, and entries never written read undefined.
module ir_pulse_width_capture (
   input  logic        clock,
   input  logic        reset,
   // Command channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] read_index
   input  logic [1:0]  req_tuser,   // [1:0] op
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] rx_state, [9:2] pulse_count, [26:10] read_data
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast,   // done_event
   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_data
);

   localparam int IW = irpwc_pkg::IDX_WIDTH;
   localparam int CW = irpwc_pkg::COUNT_WIDTH;
   localparam int PW = irpwc_pkg::PERIOD_WIDTH;
   localparam int DW = irpwc_pkg::DUR_WIDTH;
   localparam int NW = irpwc_pkg::PULSE_WIDTH;
   localparam int TW = irpwc_pkg::TOTAL_WIDTH;

   // Configuration registers.
   logic [PW-1:0] period_ff;
   logic [DW-1:0] gap_ff;
   logic [NW-1:0] maxp_ff;

   // Reception state.
   irpwc_pkg::rx_state_type state_ff, state_in;
   logic [CW-1:0] tick_ff, tick_in;
   logic [CW-1:0] start_ff, start_in;
   logic [1:0]    ovf_ff, ovf_in;
   logic [NW-1:0] pidx_ff, pidx_in;
   logic          run_ff, run_in;

   // Deferred terminator.
   logic          term_pend_ff, term_pend_in;
   logic [IW-1:0] term_idx_ff, term_idx_in;

   // Result register.
   logic          out_valid_ff;
   logic [1:0]    out_state_ff, out_state_in;
   logic          out_done_ff, out_done_in;
   logic [NW-1:0] out_count_ff, out_count_in;
   logic          out_read_ff, out_read_in;
   logic          out_fwd_ff, out_fwd_in;

   irpwc_pkg::op_type       op;
   irpwc_pkg::store_wr_type item_wr, store_wr;
   irpwc_pkg::store_rd_type store_rd;
   logic [DW-1:0]           mem_rdata;

   logic          accept;
   logic          finish;
   logic          end_limit;
   logic [TW-1:0] ovf_add;
   logic [TW-1:0] total;
   logic [TW-1:0] diff;
   logic [DW-1:0] dur;
   logic [CW:0]   tick_next;
   logic [NW-1:0] n_minus1;

   assign op         = irpwc_pkg::op_type'(req_tuser);
   assign req_tready = !out_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= irpwc_pkg::PERIOD_RESET;
         gap_ff    <= irpwc_pkg::GAP_RESET;
         maxp_ff   <= irpwc_pkg::MAXPULSE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (irpwc_pkg::reg_idx_type'(csr_index))
            irpwc_pkg::REG_PERIOD:    period_ff <= csr_data[PW-1:0];
            irpwc_pkg::REG_GAP:       gap_ff    <= csr_data[DW-1:0];
            irpwc_pkg::REG_MAXPULSES: maxp_ff   <= csr_data[NW-1:0];
            default: begin
            end
         endcase
      end
   end

   // Elapsed time since the previous edge, saturated to the duration width.
   always_comb begin
      case (ovf_ff)
         2'd1:    ovf_add = TW'(period_ff);
         2'd2:    ovf_add = TW'({period_ff, 1'b0});
         default: ovf_add = '0;
      endcase
      total = TW'(tick_ff) + ovf_add;
      diff  = (total >= TW'(start_ff)) ? (total - TW'(start_ff)) : '0;
      dur   = (diff > TW'(irpwc_pkg::DUR_MAX)) ? irpwc_pkg::DUR_MAX : diff[DW-1:0];
   end

   assign tick_next = {1'b0, tick_ff} + (CW+1)'(1);
   assign n_minus1  = pidx_ff - NW'(1);

   // Datapath: counters, store writes and the end condition.
   always_comb begin
      tick_in      = tick_ff;
      start_in     = start_ff;
      ovf_in       = ovf_ff;
      pidx_in      = pidx_ff;
      run_in       = run_ff;
      finish       = 1'b0;
      end_limit    = 1'b0;
      item_wr      = '0;
      if (accept) begin
         case (op)
            irpwc_pkg::OP_ARM: begin
               pidx_in = '0;
               tick_in = '0;
               ovf_in  = '0;
               run_in  = 1'b0;
            end
            irpwc_pkg::OP_EDGE: begin
               if (state_ff == irpwc_pkg::ST_RECV) begin
                  ovf_in   = '0;
                  start_in = tick_ff;
                  if (pidx_ff == '0) begin
                     pidx_in = NW'(1);
                     run_in  = 1'b1;
                  end else if (dur > gap_ff) begin
                     // Over-long gap: its slot becomes the terminator.
                     pidx_in      = n_minus1;
                     item_wr.en   = 1'b1;
                     item_wr.addr = IW'(n_minus1);
                     item_wr.data = '0;
                     finish       = 1'b1;
                  end else begin
                     item_wr.en   = 1'b1;
                     item_wr.addr = IW'(n_minus1);
                     item_wr.data = dur;
                     if (pidx_ff >= maxp_ff) begin
                        end_limit = 1'b1;
                        finish    = 1'b1;
                     end else begin
                        pidx_in = pidx_ff + NW'(1);
                     end
                  end
               end
            end
            irpwc_pkg::OP_TICK: begin
               if (state_ff == irpwc_pkg::ST_RECV && run_ff) begin
                  if (tick_next >= {1'b0, period_ff}) begin
                     tick_in = '0;
                     if (ovf_ff == 2'd1) begin
                        // Second overflow without an edge ends the reception.
                        ovf_in       = '0;
                        pidx_in      = n_minus1;
                        item_wr.en   = 1'b1;
                        item_wr.addr = IW'(n_minus1);
                        item_wr.data = '0;
                        finish       = 1'b1;
                     end else begin
                        ovf_in = ovf_ff + 2'd1;
                     end
                  end else begin
                     tick_in = tick_next[CW-1:0];
                  end
               end
            end
            default: begin
            end
         endcase
         if (finish) begin
            run_in = 1'b0;
         end
      end
   end

   // Next reception state.
   always_comb begin
      state_in = state_ff;
      if (accept) begin
         if (op == irpwc_pkg::OP_ARM) begin
            state_in = irpwc_pkg::ST_RECV;
         end else if (finish) begin
            state_in = irpwc_pkg::ST_END;
         end
      end
   end

   // Store port use and deferred terminator.
   always_comb begin
      term_pend_in = term_pend_ff;
      term_idx_in  = term_idx_ff;
      store_wr     = item_wr;
      if (term_pend_ff) begin
         store_wr.en   = 1'b1;
         store_wr.addr = term_idx_ff;
         store_wr.data = '0;
         term_pend_in  = 1'b0;
      end
      if (end_limit) begin
         term_pend_in = 1'b1;
         term_idx_in  = IW'(pidx_ff);
      end
      store_rd.en   = accept && (op == irpwc_pkg::OP_READ);
      store_rd.addr = req_tdata[IW-1:0];
   end

   // Result fields, taken from the state after this beat.
   always_comb begin
      out_state_in = state_in;
      out_done_in  = finish;
      case (state_in)
         irpwc_pkg::ST_RECV: out_count_in = (pidx_in != '0) ? (pidx_in - NW'(1)) : '0;
         irpwc_pkg::ST_END:  out_count_in = pidx_in;
         default:            out_count_in = '0;
      endcase
      out_read_in = (op == irpwc_pkg::OP_READ);
      out_fwd_in  = term_pend_ff && (req_tdata[IW-1:0] == term_idx_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= irpwc_pkg::ST_IDLE;
         tick_ff      <= '0;
         start_ff     <= '0;
         ovf_ff       <= '0;
         pidx_ff      <= '0;
         run_ff       <= 1'b0;
         term_pend_ff <= 1'b0;
         term_idx_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         start_ff     <= start_in;
         ovf_ff       <= ovf_in;
         pidx_ff      <= pidx_in;
         run_ff       <= run_in;
         term_pend_ff <= term_pend_in;
         term_idx_ff  <= term_idx_in;
         if (accept) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_state_ff <= out_state_in;
         out_done_ff  <= out_done_in;
         out_count_ff <= out_count_in;
         out_read_ff  <= out_read_in;
         out_fwd_ff   <= out_fwd_in;
      end
   end

   irpwc_store u_store (
      .clock    (clock),
      .wr       (store_wr),
      .rd       (store_rd),
      .rdata_ff (mem_rdata)
   );

   logic [DW-1:0] read_data;
   assign read_data = (out_read_ff && !out_fwd_ff) ? mem_rdata : '0;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, read_data, out_count_ff, out_state_ff};
   assign rsp_tlast  = out_done_ff;

   // The deferred terminator must never collide with a beat's own write.
   a_term_no_clash: assert property (@(posedge clock) disable iff (reset)
      term_pend_ff |-> !item_wr.en)
      else $error("deferred terminator collides with a store write");

   // A running counter implies an active reception with a first edge seen.
   a_run_recv: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> (state_ff == irpwc_pkg::ST_RECV) && (pidx_ff != '0))
      else $error("counter running outside an active reception");

   // The overflow count never reaches two: the second overflow clears it.
   a_ovf_range: assert property (@(posedge clock) disable iff (reset)
      ovf_ff != 2'd2 && ovf_ff != 2'd3)
      else $error("overflow count out of range");

   // A done result always reports the ended state.
   a_done_ended: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_done_ff) |-> (out_state_ff == irpwc_pkg::ST_END))
      else $error("done result without ended state");

   // A stalled result keeps its read data.
   a_hold_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(read_data))
      else $error("read data changed under stall");

endmodule
